### hdl/memory_event_coalescer_unit_defines.svh
// ============================================================================
// memory_event_coalescer_unit_defines.svh
// Assertion macros for the coalescer top level. They expand to nothing
// when SYNTHESIS is defined.
// ============================================================================
`ifndef MEMORY_EVENT_COALESCER_UNIT_DEFINES_SVH
`define MEMORY_EVENT_COALESCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that the condition implies the consequence in the same cycle.
`define MEC_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (conseq)) else $error("coalescer check failed");

// Checks that the condition implies the consequence in the following cycle.
`define MEC_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (conseq)) else $error("coalescer check failed");

`else

`define MEC_ASSERT_SAME(label, clk, rst_n, cond, conseq)
`define MEC_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

### hdl/mec_pkg.sv
// ============================================================================
// mec_pkg
// Types, codes and defaults shared by the memory event coalescer.
// ============================================================================
package mec_pkg;

    // Default number of pending entries.
    localparam int BUFFER_DEPTH_DEFAULT = 4;

    // Field widths fixed by the word formats.
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 10;
    localparam int GUARD_W = 16;

    // Input command and event kind codes.
    localparam logic [1:0] KIND_FETCH  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;
    localparam logic [1:0] KIND_MODIFY = 2'd3;
    localparam logic [1:0] CMD_FLUSH   = 2'd3;

    // One buffered event.
    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic               guard_valid;
        logic [GUARD_W-1:0] guard_id;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } ctrl_state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPEND,
        OP_MERGE,
        OP_DRAIN,
        OP_HOLD_DRAIN,
        OP_READ,
        OP_NEXT,
        OP_FINISH
    } dp_op_t;

    // Controller to datapath and handshake control.
    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
        logic   out_valid;
    } ctrl_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic is_flush;
        logic merge_hit;
        logic full;
        logic empty;
        logic last;
    } status_t;

endpackage

### hdl/mec_access_if.sv
// ============================================================================
// mec_access_if
// Input channel: one access or flush command per word.
// ============================================================================
interface mec_access_if;

    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [mec_pkg::ADDR_W-1:0]   access_addr;
    logic [mec_pkg::SIZE_W-1:0]   access_size;
    logic                         guard_valid;
    logic [mec_pkg::GUARD_W-1:0]  guard_id;

    modport source (
        output valid, command, access_addr, access_size, guard_valid, guard_id,
        input  ready
    );

    modport sink (
        input  valid, command, access_addr, access_size, guard_valid, guard_id,
        output ready
    );

endinterface

### hdl/mec_event_if.sv
// ============================================================================
// mec_event_if
// Output channel: one coalesced memory event per word.
// ============================================================================
interface mec_event_if;

    logic                         valid;
    logic                         ready;
    logic [1:0]                   event_kind;
    logic [mec_pkg::ADDR_W-1:0]   event_addr;
    logic [mec_pkg::SIZE_W-1:0]   event_size;
    logic                         event_guard_valid;
    logic [mec_pkg::GUARD_W-1:0]  event_guard_id;
    logic                         last_of_run;

    modport source (
        output valid, event_kind, event_addr, event_size, event_guard_valid,
               event_guard_id, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, event_kind, event_addr, event_size, event_guard_valid,
               event_guard_id, last_of_run,
        output ready
    );

endinterface

### hdl/mec_ctrl.sv
// ============================================================================
// mec_ctrl
// Controller of the coalescer: takes input words while idle and sequences
// the drain of the entry buffer, one registered read per output word.
// ============================================================================
module mec_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_ready,
    input  mec_pkg::status_t status,
    output mec_pkg::ctrl_t   ctrl
);

    mec_pkg::ctrl_state_t state_reg;
    mec_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mec_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mec_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (status.is_flush)
                    begin
                        if (!status.empty)
                        begin
                            state_next = mec_pkg::ST_READ;
                        end
                    end
                    else if (!status.merge_hit && status.full)
                    begin
                        state_next = mec_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = mec_pkg::ST_IDLE;
                    end
                end
            end
            mec_pkg::ST_READ:
            begin
                state_next = mec_pkg::ST_SEND;
            end
            mec_pkg::ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = status.last ? mec_pkg::ST_IDLE : mec_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = mec_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake controls and the datapath operation.
    always_comb
    begin
        ctrl.op        = mec_pkg::OP_NONE;
        ctrl.in_ready  = 1'b0;
        ctrl.out_valid = 1'b0;
        unique case (state_reg)
            mec_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (status.is_flush)
                    begin
                        ctrl.op = status.empty ? mec_pkg::OP_NONE : mec_pkg::OP_DRAIN;
                    end
                    else if (status.merge_hit)
                    begin
                        ctrl.op = mec_pkg::OP_MERGE;
                    end
                    else if (status.full)
                    begin
                        ctrl.op = mec_pkg::OP_HOLD_DRAIN;
                    end
                    else
                    begin
                        ctrl.op = mec_pkg::OP_APPEND;
                    end
                end
            end
            mec_pkg::ST_READ:
            begin
                ctrl.op = mec_pkg::OP_READ;
            end
            mec_pkg::ST_SEND:
            begin
                ctrl.out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.op = status.last ? mec_pkg::OP_FINISH : mec_pkg::OP_NEXT;
                end
            end
            default:
            begin
                ctrl.op = mec_pkg::OP_NONE;
            end
        endcase
    end

endmodule

### hdl/mec_datapath.sv
// ============================================================================
// mec_datapath
// Entry memory, pending count, tail copy for merge checks, the held word of
// a full-buffer drain, and the registered read that feeds the output.
// ============================================================================
module mec_datapath #(
    parameter int BUFFER_DEPTH = mec_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mec_pkg::ctrl_t               ctrl,
    input  logic [1:0]                   command,
    input  logic [mec_pkg::ADDR_W-1:0]   access_addr,
    input  logic [mec_pkg::SIZE_W-1:0]   access_size,
    input  logic                         guard_valid,
    input  logic [mec_pkg::GUARD_W-1:0]  guard_id,
    output mec_pkg::status_t             status,
    output logic [1:0]                   event_kind,
    output logic [mec_pkg::ADDR_W-1:0]   event_addr,
    output logic [mec_pkg::SIZE_W-1:0]   event_size,
    output logic                         event_guard_valid,
    output logic [mec_pkg::GUARD_W-1:0]  event_guard_id,
    output logic                         last_of_run
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    mec_pkg::entry_t entry_mem [BUFFER_DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;
    logic             hold_pend_reg;
    logic             hold_pend_next;
    mec_pkg::entry_t  hold_reg;
    mec_pkg::entry_t  tail_reg;
    mec_pkg::entry_t  rdata_reg;

    mec_pkg::entry_t  new_entry;
    mec_pkg::entry_t  merged_entry;
    logic             new_guarded;
    logic [CNT_W-1:0] tail_cnt;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    mec_pkg::entry_t  mem_wdata;

    // Incoming word as it would be stored; fetches never carry a guard.
    always_comb
    begin
        new_guarded           = guard_valid && (command != mec_pkg::KIND_FETCH);
        new_entry.kind        = command;
        new_entry.addr        = access_addr;
        new_entry.size        = access_size;
        new_entry.guard_valid = new_guarded;
        new_entry.guard_id    = new_guarded ? guard_id : '0;
        merged_entry          = tail_reg;
        merged_entry.kind     = mec_pkg::KIND_MODIFY;
    end

    // Status for the controller.
    assign tail_cnt         = count_reg - CNT_W'(1);
    assign status.is_flush  = (command == mec_pkg::CMD_FLUSH);
    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == CNT_W'(BUFFER_DEPTH));
    assign status.last      = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign status.merge_hit = (command == mec_pkg::KIND_WRITE) && !guard_valid &&
                              (count_reg != '0) &&
                              (tail_reg.kind == mec_pkg::KIND_READ) &&
                              !tail_reg.guard_valid &&
                              (tail_reg.size == access_size) &&
                              (tail_reg.addr == access_addr);

    // Memory write port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = new_entry;
        unique case (ctrl.op)
            mec_pkg::OP_APPEND:
            begin
                mem_we = 1'b1;
            end
            mec_pkg::OP_MERGE:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_cnt[IDX_W-1:0];
                mem_wdata = merged_entry;
            end
            mec_pkg::OP_FINISH:
            begin
                mem_we    = hold_pend_reg;
                mem_waddr = '0;
                mem_wdata = hold_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Next values of the control registers.
    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        hold_pend_next = hold_pend_reg;
        unique case (ctrl.op)
            mec_pkg::OP_APPEND:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            mec_pkg::OP_DRAIN:
            begin
                rd_idx_next = '0;
            end
            mec_pkg::OP_HOLD_DRAIN:
            begin
                rd_idx_next    = '0;
                hold_pend_next = 1'b1;
            end
            mec_pkg::OP_NEXT:
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
            mec_pkg::OP_FINISH:
            begin
                count_next     = hold_pend_reg ? CNT_W'(1) : '0;
                hold_pend_next = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            hold_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            hold_pend_reg <= hold_pend_next;
        end
    end

    // Held word and tail copy.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == mec_pkg::OP_HOLD_DRAIN)
        begin
            hold_reg <= new_entry;
        end
        if (ctrl.op == mec_pkg::OP_APPEND)
        begin
            tail_reg <= new_entry;
        end
        else if (ctrl.op == mec_pkg::OP_MERGE)
        begin
            tail_reg <= merged_entry;
        end
        else if (ctrl.op == mec_pkg::OP_FINISH && hold_pend_reg)
        begin
            tail_reg <= hold_reg;
        end
    end

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.op == mec_pkg::OP_READ)
        begin
            rdata_reg <= entry_mem[rd_idx_reg];
        end
    end

    // Output word straight from the read register.
    assign event_kind        = rdata_reg.kind;
    assign event_addr        = rdata_reg.addr;
    assign event_size        = rdata_reg.size;
    assign event_guard_valid = rdata_reg.guard_valid;
    assign event_guard_id    = rdata_reg.guard_id;
    assign last_of_run       = status.last;

endmodule

### hdl/memory_event_coalescer_unit.sv
// ============================================================================
// memory_event_coalescer_unit: an absorbed or merged access is taken without leaving idle.
// A flush or a full buffer drains word by word via the single registered read
// port of the entry memory; no input is taken meanwhile.
// rst_n clears the pending count and the controller at once.
// ============================================================================
`include "memory_event_coalescer_unit_defines.svh"

module memory_event_coalescer_unit #(
    parameter int BUFFER_DEPTH = mec_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    mec_access_if.sink        access,
    mec_event_if.source       events
);

    mec_pkg::ctrl_t   ctrl;
    mec_pkg::status_t status;

    // Controller.
    mec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (access.valid),
        .out_ready (events.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // Datapath.
    mec_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .command           (access.command),
        .access_addr       (access.access_addr),
        .access_size       (access.access_size),
        .guard_valid       (access.guard_valid),
        .guard_id          (access.guard_id),
        .status            (status),
        .event_kind        (events.event_kind),
        .event_addr        (events.event_addr),
        .event_size        (events.event_size),
        .event_guard_valid (events.event_guard_valid),
        .event_guard_id    (events.event_guard_id),
        .last_of_run       (events.last_of_run)
    );

    // Handshake controls.
    assign access.ready = ctrl.in_ready;
    assign events.valid = ctrl.out_valid;

    // The block never takes input while it is presenting an output word.
    `MEC_ASSERT_SAME(a_no_overlap, clk, rst_n, access.ready, !events.valid)
    // The last word of a run returns the block to idle.
    `MEC_ASSERT_NEXT(a_last_ends_run, clk, rst_n, events.valid && events.ready && events.last_of_run, !events.valid && access.ready)
    // A flush of a non-empty buffer stops input on the next cycle.
    `MEC_ASSERT_NEXT(a_flush_drains, clk, rst_n, access.valid && access.ready && status.is_flush && !status.empty, !access.ready)

endmodule

### sim/memory_event_coalescer_unit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// memory_event_coalescer_unit_checker
// Watches the access and event channels of the coalescer. Every accepted
// access word updates a local copy of the pending buffer, and the event words
// that this access should release are queued. Event words that the block
// sends are queued as well, and the two queues are compared word by word,
// oldest first. The words of a drain leave the block only after the access
// that causes it is taken, so observed words pair with words already queued.
// ============================================================================
module memory_event_coalescer_unit_checker (
    input  logic  clk,
    input  logic  rst_n,
    mec_access_if access,
    mec_event_if  events,
    output int    fail_count,
    output int    words_in_flight
);

    // One event word together with its end-of-run mark.
    typedef struct packed {
        mec_pkg::entry_t ev;
        logic            last;
    } event_word_t;

    mec_pkg::entry_t pending_entries[$];
    event_word_t     expected_events[$];
    event_word_t     observed_events[$];

    // Sends every pending entry out in order and empties the buffer.
    task automatic release_pending();
        event_word_t w;
        for (int i = 0; i < pending_entries.size(); i++)
        begin
            w.ev   = pending_entries[i];
            w.last = (i == pending_entries.size() - 1);
            expected_events.push_back(w);
        end
        pending_entries.delete();
    endtask

    // Applies one access or flush to the pending buffer.
    task automatic coalesce_access(
        input logic [1:0]                  cmd,
        input logic [mec_pkg::ADDR_W-1:0]  addr,
        input logic [mec_pkg::SIZE_W-1:0]  size,
        input logic                        gv,
        input logic [mec_pkg::GUARD_W-1:0] gid
    );
        mec_pkg::entry_t e;
        int              tail;
        if (cmd == mec_pkg::CMD_FLUSH)
        begin
            release_pending();
            return;
        end
        // A fetch is never guarded; an unguarded access carries guard id zero.
        if (cmd == mec_pkg::KIND_FETCH)
            gv = 1'b0;
        if (!gv)
            gid = '0;
        // An unguarded write folds into a matching unguarded read at the tail.
        if (cmd == mec_pkg::KIND_WRITE && !gv && pending_entries.size() > 0)
        begin
            tail = pending_entries.size() - 1;
            if (pending_entries[tail].kind == mec_pkg::KIND_READ &&
                pending_entries[tail].size == size &&
                !pending_entries[tail].guard_valid &&
                pending_entries[tail].addr == addr)
            begin
                pending_entries[tail].kind = mec_pkg::KIND_MODIFY;
                return;
            end
        end
        if (pending_entries.size() >= mec_pkg::BUFFER_DEPTH_DEFAULT)
            release_pending();
        e.kind        = cmd;
        e.addr        = addr;
        e.size        = size;
        e.guard_valid = gv;
        e.guard_id    = gid;
        pending_entries.push_back(e);
    endtask

    function automatic int field_mismatch(string name, logic [63:0] exp_v,
                                          logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Sample both channels at the rising edge and pair up words.
    always @(posedge clk)
    begin
        event_word_t got;
        event_word_t want;
        int          bad;
        if (rst_n)
        begin
            if (access.valid && access.ready)
                coalesce_access(access.command, access.access_addr,
                                access.access_size, access.guard_valid,
                                access.guard_id);
            if (events.valid && events.ready)
            begin
                got.ev.kind        = events.event_kind;
                got.ev.addr        = events.event_addr;
                got.ev.size        = events.event_size;
                got.ev.guard_valid = events.event_guard_valid;
                got.ev.guard_id    = events.event_guard_id;
                got.last           = events.last_of_run;
                observed_events.push_back(got);
            end
            while (expected_events.size() > 0 && observed_events.size() > 0)
            begin
                want = expected_events.pop_front();
                got  = observed_events.pop_front();
                bad  = 0;
                bad += field_mismatch("event_kind", 64'(want.ev.kind),
                                      64'(got.ev.kind));
                bad += field_mismatch("event_addr", want.ev.addr, got.ev.addr);
                bad += field_mismatch("event_size", 64'(want.ev.size),
                                      64'(got.ev.size));
                bad += field_mismatch("event_guard_valid", 64'(want.ev.guard_valid),
                                      64'(got.ev.guard_valid));
                bad += field_mismatch("event_guard_id", 64'(want.ev.guard_id),
                                      64'(got.ev.guard_id));
                bad += field_mismatch("last_of_run", 64'(want.last), 64'(got.last));
                if (bad != 0)
                    fail_count++;
            end
            words_in_flight = expected_events.size() + observed_events.size();
        end
    end

endmodule

### sim/memory_event_coalescer_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// memory_event_coalescer_unit_tb
// Drives access words into the coalescer in bursts while the event side
// stalls on its own pattern, including one long hold-off that fills the
// buffer. A directed opening covers merging, guards, odd sizes and flushes;
// random traffic follows, mostly read/write pairs that can merge.
// ============================================================================
module memory_event_coalescer_unit_tb;

    localparam int ITEM_TARGET   = 260;
    localparam int HOLD_OFF      = 200;
    localparam int HOLD_AT_CYCLE = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   words_in_flight;
    int   items_sent;
    int   burst_left;

    mec_access_if acc ();
    mec_event_if  evt ();

    memory_event_coalescer_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (acc),
        .events (evt)
    );

    memory_event_coalescer_unit_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .access          (acc),
        .events          (evt),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    always #5 clk = ~clk;

    // Offers one access word, opening a new burst after a random gap.
    task automatic send_access(
        input logic [1:0]                  cmd,
        input logic [mec_pkg::ADDR_W-1:0]  addr,
        input logic [mec_pkg::SIZE_W-1:0]  size,
        input logic                        gv,
        input logic [mec_pkg::GUARD_W-1:0] gid
    );
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            repeat (gap)
            begin
                @(negedge clk);
                acc.valid = 1'b0;
            end
        end
        @(negedge clk);
        acc.valid       = 1'b1;
        acc.command     = cmd;
        acc.access_addr = addr;
        acc.access_size = size;
        acc.guard_valid = gv;
        acc.guard_id    = gid;
        do
            @(posedge clk);
        while (!acc.ready);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [mec_pkg::ADDR_W-1:0] random_addr();
        case ($urandom_range(0, 3))
            0:       return {$urandom(), $urandom()} & 64'h0000_0000_0000_01C0;
            1:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [mec_pkg::SIZE_W-1:0] random_size();
        if ($urandom_range(0, 9) < 7)
            return mec_pkg::SIZE_W'($urandom_range(1, 512));
        return mec_pkg::SIZE_W'($urandom_range(0, 1023));
    endfunction

    // Event side: changing stall patterns, with one long hold-off.
    initial
    begin
        int cyc;
        int mode;
        int span;
        evt.ready = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(negedge clk);
                cyc++;
                if (cyc == HOLD_AT_CYCLE)
                begin
                    evt.ready = 1'b0;
                    repeat (HOLD_OFF) @(negedge clk);
                end
                case (mode)
                    0:       evt.ready = 1'b1;
                    1:       evt.ready = ($urandom_range(0, 3) != 0);
                    2:       evt.ready = (cyc % 3 == 0);
                    default: evt.ready = 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((acc.valid && acc.ready) || (evt.valid && evt.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("memory_event_coalescer_unit test failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        logic [mec_pkg::ADDR_W-1:0]  a;
        logic [mec_pkg::SIZE_W-1:0]  s;
        logic [mec_pkg::GUARD_W-1:0] g;
        int                          pick;
        clk             = 1'b0;
        rst_n           = 1'b0;
        acc.valid       = 1'b0;
        acc.command     = mec_pkg::KIND_FETCH;
        acc.access_addr = '0;
        acc.access_size = '0;
        acc.guard_valid = 1'b0;
        acc.guard_id    = '0;
        items_sent      = 0;
        burst_left      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Guarded fetch, then a read with a stray guard id that merges.
        send_access(mec_pkg::KIND_FETCH, 64'h0, 10'd1, 1'b1, 16'hFFFF);
        send_access(mec_pkg::KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 10'd512, 1'b0, 16'hA5A5);
        send_access(mec_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd512, 1'b0, 16'h5A5A);
        send_access(mec_pkg::CMD_FLUSH, 64'h0, 10'd0, 1'b0, 16'h0);
        // Flush with nothing pending.
        send_access(mec_pkg::CMD_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b1, 16'hFFFF);
        // A guarded read never absorbs a write, nor does a guarded write merge.
        send_access(mec_pkg::KIND_READ, 64'h8000_0000_0000_0001, 10'd8, 1'b1, 16'hFFFF);
        send_access(mec_pkg::KIND_WRITE, 64'h8000_0000_0000_0001, 10'd8, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_READ, 64'h0123_4567_89AB_CDEF, 10'd16, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'h0123_4567_89AB_CDEF, 10'd16, 1'b1, 16'h0);
        // Buffer is full: the next entry drains it first. Size zero still merges.
        send_access(mec_pkg::KIND_READ, 64'h0, 10'd0, 1'b0, 16'h1234);
        send_access(mec_pkg::KIND_WRITE, 64'h0, 10'd0, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1022, 1'b0, 16'h0);
        // Merge into the tail of a full buffer, then overflow it.
        send_access(mec_pkg::KIND_READ, 64'h0123_4567_89AB_CDEF, 10'd64, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'h0123_4567_89AB_CDEF, 10'd64, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'h0123_4567_89AB_CDF0, 10'd64, 1'b0, 16'h0);
        send_access(mec_pkg::CMD_FLUSH, 64'h0, 10'd0, 1'b0, 16'h0);
        // Near misses on size and address.
        send_access(mec_pkg::KIND_READ, 64'h8000_0000_0000_0001, 10'd4, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'h8000_0000_0000_0001, 10'd8, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_READ, 64'h0, 10'd4, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_WRITE, 64'h1, 10'd4, 1'b0, 16'h0);
        send_access(mec_pkg::CMD_FLUSH, 64'h0, 10'd0, 1'b0, 16'h0);
        send_access(mec_pkg::KIND_FETCH, 64'hDEAD_BEEF_0000_0000, 10'd512, 1'b0, 16'hFFFF);
        send_access(mec_pkg::CMD_FLUSH, 64'h0, 10'd0, 1'b0, 16'h0);

        // Random traffic, weighted toward read/write pairs that can merge.
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            a    = random_addr();
            s    = random_size();
            g    = mec_pkg::GUARD_W'($urandom_range(0, 65535));
            if (pick < 45)
            begin
                send_access(mec_pkg::KIND_READ, a, s, ($urandom_range(0, 9) == 0), g);
                case ($urandom_range(0, 9))
                    0:       a = a ^ (64'h1 << $urandom_range(0, 63));
                    1:       s = s ^ (10'h1 << $urandom_range(0, 9));
                    default: ;
                endcase
                send_access(mec_pkg::KIND_WRITE, a, s, ($urandom_range(0, 9) == 0), g);
            end
            else if (pick < 65)
                send_access(2'($urandom_range(mec_pkg::KIND_FETCH, mec_pkg::KIND_WRITE)),
                            a, s, 1'($urandom_range(0, 1)), g);
            else if (pick < 75)
                send_access(mec_pkg::CMD_FLUSH, a, s, 1'($urandom_range(0, 1)), g);
            else if (pick < 85)
                send_access(mec_pkg::KIND_FETCH, a, s, 1'b1, g);
            else
                send_access(2'($urandom_range(0, 3)), {$urandom(), $urandom()},
                            mec_pkg::SIZE_W'($urandom_range(0, 1023)),
                            1'($urandom_range(0, 1)), g);
        end
        send_access(mec_pkg::CMD_FLUSH, 64'h0, 10'd0, 1'b0, 16'h0);
        @(negedge clk);
        acc.valid = 1'b0;

        while (words_in_flight != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && words_in_flight == 0)
            $display("memory_event_coalescer_unit test passed");
        else
            $display("memory_event_coalescer_unit test failed");
        $finish;
    end

endmodule
